// File: hdl/abp_pkg.sv
// Shared types and constants for the alpha blend pixel core.
`timescale 1ns / 1ps
`default_nettype none

package abp_pkg;

  // Destination pixel formats
  typedef enum logic {
    FMT_XRGB8888 = 1'b0,
    FMT_RGB565   = 1'b1
  } dest_fmt_e;

  // Alpha codes with special handling
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // Rounding bias of the channel blend
  localparam logic signed [17:0] BLEND_ROUND = 18'sh00080;

  // One input item
  typedef struct packed {
    logic [7:0]  fg_alpha;
    logic [7:0]  fg_red;
    logic [7:0]  fg_green;
    logic [7:0]  fg_blue;
    logic [31:0] dest_pixel;
  } px_item_t;

  // One result item
  typedef struct packed {
    logic [31:0] new_pixel;
    logic        write_enable;
  } px_result_t;

endpackage

`default_nettype wire

// File: hdl/abp_chan.sv
// One 8-bit channel blend: d + round((a * (s - d)) / 255), wrapped to 8 bits.
`timescale 1ns / 1ps
`default_nettype none

module abp_chan (
  input  wire logic [7:0] alpha_i,
  input  wire logic [7:0] src_i,
  input  wire logic [7:0] dst_i,
  output logic      [7:0] blend_o
);

  logic signed [8:0]  diff;
  logic signed [17:0] alpha_x;
  logic signed [17:0] diff_x;
  logic signed [17:0] prod;
  logic signed [17:0] sum;
  logic signed [17:0] quot;

  // Signed difference times alpha; |prod| <= 65025 fits in 18 bits
  assign diff    = $signed({1'b0, src_i}) - $signed({1'b0, dst_i});
  assign alpha_x = $signed({10'b0, alpha_i});
  assign diff_x  = {{9{diff[8]}}, diff};
  assign prod    = alpha_x * diff_x;

  // t + (t >>> 8) + 0x80, then arithmetic shift by 8
  assign sum  = prod + (prod >>> 8) + abp_pkg::BLEND_ROUND;
  assign quot = sum >>> 8;

  // Only the low byte of the quotient matters after wrapping
  assign blend_o = dst_i + quot[7:0];

endmodule

`default_nettype wire

// File: hdl/abp_datapath.sv
// Format unpack, three channel blends, alpha special cases and repack.
`timescale 1ns / 1ps
`default_nettype none

module abp_datapath (
  input  wire abp_pkg::px_item_t  item_i,
  input  wire abp_pkg::dest_fmt_e fmt_i,
  output abp_pkg::px_result_t     result_o
);

  logic [7:0]  lo, hi;
  logic [7:0]  dst_r, dst_g, dst_b;
  logic [7:0]  bl_r, bl_g, bl_b;
  logic [7:0]  fin_r, fin_g, fin_b;
  logic        is_clear, is_opaque;
  logic [15:0] packed565;

  assign lo = item_i.dest_pixel[7:0];
  assign hi = item_i.dest_pixel[15:8];

  assign is_clear  = (item_i.fg_alpha == abp_pkg::ALPHA_CLEAR);
  assign is_opaque = (item_i.fg_alpha == abp_pkg::ALPHA_OPAQUE);

  // Destination channels; RGB565 expands with zero low bits
  always_comb begin
    case (fmt_i)
      abp_pkg::FMT_RGB565: begin
        dst_r = {hi[7:3], 3'b000};
        dst_g = {hi[2:0], lo[7:5], 2'b00};
        dst_b = {lo[4:0], 3'b000};
      end
      default: begin
        dst_b = item_i.dest_pixel[7:0];
        dst_g = item_i.dest_pixel[15:8];
        dst_r = item_i.dest_pixel[23:16];
      end
    endcase
  end

  abp_chan u_chan_r (
    .alpha_i (item_i.fg_alpha),
    .src_i   (item_i.fg_red),
    .dst_i   (dst_r),
    .blend_o (bl_r)
  );

  abp_chan u_chan_g (
    .alpha_i (item_i.fg_alpha),
    .src_i   (item_i.fg_green),
    .dst_i   (dst_g),
    .blend_o (bl_g)
  );

  abp_chan u_chan_b (
    .alpha_i (item_i.fg_alpha),
    .src_i   (item_i.fg_blue),
    .dst_i   (dst_b),
    .blend_o (bl_b)
  );

  // Opaque source copies straight through
  assign fin_r = is_opaque ? item_i.fg_red   : bl_r;
  assign fin_g = is_opaque ? item_i.fg_green : bl_g;
  assign fin_b = is_opaque ? item_i.fg_blue  : bl_b;

  // RGB565 repack: high byte {r[7:3], g[7:5]}, low byte {g[4:2], b[7:3]}
  assign packed565 = {fin_r[7:3], fin_g[7:5], fin_g[4:2], fin_b[7:3]};

  // Final pixel and write flag
  always_comb begin
    result_o.write_enable = !is_clear;
    case (fmt_i)
      abp_pkg::FMT_RGB565: begin
        if (is_clear) begin
          result_o.new_pixel = {16'h0000, item_i.dest_pixel[15:0]};
        end else begin
          result_o.new_pixel = {16'h0000, packed565};
        end
      end
      default: begin
        if (is_clear) begin
          result_o.new_pixel = item_i.dest_pixel;
        end else begin
          result_o.new_pixel = {8'h00, fin_r, fin_g, fin_b};
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/alpha_blend_pixel_core.sv
// Top level of the alpha blend pixel core: registers, handshake and format register.
`timescale 1ns / 1ps
`default_nettype none

// Blends an 8-bit ARGB source pixel over a destination pixel held either as a
// 32-bit word (blue, green, red, pad byte from bit 0 up) or as a 16-bit RGB565
// word in the low half. One item is accepted per clock while the output does
// not stall; each item is captured in the input register, passes the blend
// logic (three 8x9 multiplies in parallel) and lands in the result register,
// which drives out_valid_o. An output stall holds both registers; otherwise
// throughput is one pixel per clock. Alpha 0 returns the destination with
// write_enable low; in RGB565 mode bits 31..16 of the result are always zero.
// The format register is written through the cfg channel, which is always
// ready, and must only change while the core is empty.

module alpha_blend_pixel_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_dest_format_i,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  fg_alpha_i,
  input  wire logic [7:0]  fg_red_i,
  input  wire logic [7:0]  fg_green_i,
  input  wire logic [7:0]  fg_blue_i,
  input  wire logic [31:0] dest_pixel_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      new_pixel_o,
  output logic             write_enable_o
);

  abp_pkg::dest_fmt_e  fmt_q;
  abp_pkg::px_item_t   item_q;
  abp_pkg::px_result_t res_q;
  abp_pkg::px_result_t dp_res;
  logic                s1_valid_q;
  logic                out_valid_q;
  logic                s1_adv;
  logic                in_fire;

  // Format register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= abp_pkg::FMT_XRGB8888;
    end else if (cfg_valid_i) begin
      fmt_q <= abp_pkg::dest_fmt_e'(cfg_dest_format_i);
    end
  end

  // Pipeline flow: stage 1 moves on when the result register is free or draining
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Input item register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.fg_alpha   <= fg_alpha_i;
      item_q.fg_red     <= fg_red_i;
      item_q.fg_green   <= fg_green_i;
      item_q.fg_blue    <= fg_blue_i;
      item_q.dest_pixel <= dest_pixel_i;
    end
  end

  abp_datapath u_datapath (
    .item_i   (item_q),
    .fmt_i    (fmt_q),
    .result_o (dp_res)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      res_q <= dp_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_pixel_o    = res_q.new_pixel;
  assign write_enable_o = res_q.write_enable;

  // A transparent item reaches the output with the write flag low
  a_clear_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv && (item_q.fg_alpha == abp_pkg::ALPHA_CLEAR)
    |=> out_valid_q && !res_q.write_enable)
    else $error("transparent item produced a write");

  // RGB565 results never carry an upper half
  a_565_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (fmt_q == abp_pkg::FMT_RGB565) |-> (dp_res.new_pixel[31:16] == 16'h0000))
    else $error("RGB565 result has nonzero upper half");

  // Opaque source in 32-bit mode is copied with a cleared pad byte
  a_opaque_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (fmt_q == abp_pkg::FMT_XRGB8888) &&
    (item_q.fg_alpha == abp_pkg::ALPHA_OPAQUE)
    |-> (dp_res.new_pixel == {8'h00, item_q.fg_red, item_q.fg_green, item_q.fg_blue}))
    else $error("opaque copy mismatch");

  // A blocked stage-1 item is kept, not dropped
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(item_q))
    else $error("stalled item lost in stage 1");

endmodule

`default_nettype wire
